// ===== rtl/fpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float pixel packer package
// Shared types, format codes, constants and single-precision arithmetic.
// ----------------------------------------------------------------------------
package fpp_pkg;

  typedef enum logic [2:0] {
    FMT_RGBA8     = 3'd0,
    FMT_RGBA16    = 3'd1,
    FMT_RGBA_HALF = 3'd2,
    FMT_RGBA_F32  = 3'd3,
    FMT_GRAY8     = 3'd4,
    FMT_GRAY_HALF = 3'd5,
    FMT_GRAY_F32  = 3'd6,
    FMT_NONE      = 3'd7
  } fmt_t;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [31:0] F_C299  = 32'h3E99_1687;
  localparam logic [31:0] F_C587  = 32'h3F16_45A2;
  localparam logic [31:0] F_C114  = 32'h3DE9_78D5;
  localparam logic [31:0] F_255   = 32'h437F_0000;
  localparam logic [31:0] F_65535 = 32'h477F_FF00;
  localparam logic [31:0] F_HALF  = 32'h3F00_0000;
  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_QNAN  = 32'h7FC0_0000;
  localparam logic [15:0] H_INF   = 16'h7C00;

  // One pixel as it waits between the front and the back end.
  typedef struct packed {
    fmt_t        fmt;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } item_t;

  // Payload carried down the arithmetic pipeline.
  typedef struct packed {
    fmt_t             fmt;
    logic [63:0]      w0;
    logic [63:0]      w1;
    logic [3:0][31:0] a;
    logic [2:0][31:0] gp;
    logic [31:0]      g;
  } stg_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  // Rounds a normalized significand (leading one at bit 47) with biased
  // exponent e to nearest even, producing normal, subnormal or infinity.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                           input logic [47:0] sig);
    logic signed [11:0] sub_sh;
    logic [5:0]  shamt;
    logic [7:0]  ef;
    logic [47:0] shv;
    logic        lost;
    logic [22:0] mant;
    logic        rnd;
    logic [30:0] r;
    sub_sh = 12'sd1 - e;
    if (e >= 12'sd1) begin
      shamt = 6'd0;
      ef    = e[7:0];
    end else begin
      shamt = (sub_sh > 12'sd48) ? 6'd48 : sub_sh[5:0];
      ef    = 8'd0;
    end
    shv  = sig >> shamt;
    lost = |(sig & ~({48{1'b1}} << shamt));
    mant = shv[46:24];
    rnd  = shv[23] & ((|shv[22:0]) | lost | mant[0]);
    r    = {ef, mant} + {30'd0, rnd};
    if (e >= 12'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    return {sign, r};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sign;
    logic [23:0]        sa;
    logic [23:0]        sb;
    logic [8:0]         ea;
    logic [8:0]         eb;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic signed [11:0] e;
    sign = a[31] ^ b[31];
    sa   = {a[30:23] != 8'd0, a[22:0]};
    sb   = {b[30:23] != 8'd0, b[22:0]};
    ea   = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb   = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    p    = sa * sb;
    lz   = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    e = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (a[30:23] == 8'hFF) return (b[30:0] == 31'd0) ? F_QNAN : {sign, 8'hFF, 23'd0};
    if (b[30:23] == 8'hFF) return (a[30:0] == 31'd0) ? F_QNAN : {sign, 8'hFF, 23'd0};
    if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) return {sign, 31'd0};
    return fp_round(sign, e, p << lz);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        big;
    logic [31:0]        sml;
    logic [8:0]         eb;
    logic [8:0]         es;
    logic [7:0]         d;
    logic [5:0]         dsh;
    logic [49:0]        xa;
    logic [49:0]        xs0;
    logic [49:0]        xs;
    logic [49:0]        sum;
    logic [49:0]        nrm;
    logic [5:0]         lz;
    logic signed [11:0] e;
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb  = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    es  = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
    d   = 8'(eb - es);
    dsh = (d > 8'd50) ? 6'd50 : d[5:0];
    xa  = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
    xs0 = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
    xs  = xs0 >> dsh;
    xs[0] = xs[0] | (|(xs0 & ~({50{1'b1}} << dsh)));
    sum = (big[31] == sml[31]) ? (xa + xs) : (xa - xs);
    lz  = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (sum[i]) lz = 6'(49 - i);
    end
    nrm = sum << lz;
    e   = $signed({3'd0, eb}) + 12'sd1 - $signed({6'd0, lz});
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if ((a[30:23] == 8'hFF) && (b[30:23] == 8'hFF) && (a[31] != b[31])) return F_QNAN;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (sum == 50'd0) return 32'd0;
    return fp_round(big[31], e, {nrm[49:3], nrm[2] | nrm[1] | nrm[0]});
  endfunction

  // Clamp to [0,1]; a NaN passes unchanged.
  function automatic logic [31:0] fp_clamp01(input logic [31:0] x);
    if (is_nan(x)) return x;
    if (x[31] && (x[30:0] != 31'd0)) return 32'd0;
    if (!x[31] && (x[30:0] > F_ONE[30:0])) return F_ONE;
    return x;
  endfunction

  // Truncating cast of a non-negative value below 65536; NaN gives zero.
  function automatic logic [15:0] fp_to_u16(input logic [31:0] x);
    logic [23:0] sig;
    logic [7:0]  sh;
    sig = {1'b1, x[22:0]};
    sh  = 8'd150 - x[30:23];
    if ((x[30:23] < 8'd127) || (x[30:23] > 8'd150)) return 16'd0;
    return 16'(sig >> sh[4:0]);
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] x);
    logic [7:0] ef;
    logic [4:0] eh;
    ef = x[30:23];
    eh = 5'(ef - 8'd112);
    if (ef == 8'd0) return {x[31], 15'd0};
    if (ef > 8'd142) return {x[31], H_INF[14:0]};
    if (ef < 8'd113) return {x[31], 15'd0};
    return {x[31], eh, x[22:13]};
  endfunction

  function automatic logic [3:0] fmt_bytes(input fmt_t f);
    case (f)
      FMT_RGBA8:     return 4'd4;
      FMT_RGBA16:    return 4'd8;
      FMT_RGBA_HALF: return 4'd8;
      FMT_RGBA_F32:  return 4'd8;
      FMT_GRAY8:     return 4'd1;
      FMT_GRAY_HALF: return 4'd2;
      FMT_GRAY_F32:  return 4'd4;
      default:       return 4'd4;
    endcase
  endfunction

endpackage

// ===== rtl/fpp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float pixel packer front end
// Holds the format register, tags each item and queues it for the back end.
// ----------------------------------------------------------------------------
module fpp_front import fpp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_out_format,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_red,
  input  logic [31:0] in_green,
  input  logic [31:0] in_blue,
  input  logic [31:0] in_alpha,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fmt_t          fmt_r;
  item_t         q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;
  item_t         new_item;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    new_item.fmt       = fmt_r;
    new_item.red       = in_red;
    new_item.green     = in_green;
    new_item.blue      = in_blue;
    new_item.alpha     = in_alpha;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RGBA8;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        fmt_r <= fmt_t'(cfg_out_format);
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== rtl/fpp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float pixel packer back end
// Five-stage float pipeline followed by the result register and word sequencer.
// ----------------------------------------------------------------------------
module fpp_back import fpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_packed_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last
);

  logic [4:0]  v_r;
  stg_t        st_r [5];
  stg_t        s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt;
  logic        en;
  logic        out_free;
  logic        out_v_r, out_phase_r, out_two_r;
  logic [63:0] out_w0_r, out_w1_r, w_nxt;
  logic [3:0]  out_cnt_r;
  logic [31:0] scale;
  logic [15:0] gu;
  logic [15:0] u [4];

  assign out_free = !out_v_r || (pop && out_last);
  assign en       = !v_r[4] || out_free;
  assign q_pop    = en && q_valid;

  // Stage 1: clamp and scale the channels, gray products, direct formats.
  always_comb begin
    scale         = (q_item.fmt == FMT_RGBA16) ? F_65535 : F_255;
    s1_nxt        = '0;
    s1_nxt.fmt    = q_item.fmt;
    s1_nxt.a[0]   = fp_mul(fp_clamp01(q_item.red), scale);
    s1_nxt.a[1]   = fp_mul(fp_clamp01(q_item.green), scale);
    s1_nxt.a[2]   = fp_mul(fp_clamp01(q_item.blue), scale);
    s1_nxt.a[3]   = fp_mul(fp_clamp01(q_item.alpha), scale);
    s1_nxt.gp[0]  = fp_mul(F_C299, q_item.red);
    s1_nxt.gp[1]  = fp_mul(F_C587, q_item.green);
    s1_nxt.gp[2]  = fp_mul(F_C114, q_item.blue);
    s1_nxt.w1     = {q_item.alpha, q_item.blue};
    if (q_item.fmt == FMT_RGBA_HALF) begin
      s1_nxt.w0 = {to_half(q_item.alpha), to_half(q_item.blue),
                   to_half(q_item.green), to_half(q_item.red)};
    end else if (q_item.fmt == FMT_RGBA_F32) begin
      s1_nxt.w0 = {q_item.green, q_item.red};
    end
  end

  // Stage 2: rounding offset, first gray sum.
  always_comb begin
    s2_nxt = st_r[0];
    for (int i = 0; i < 4; i++) begin
      s2_nxt.a[i] = fp_add(st_r[0].a[i], F_HALF);
    end
    s2_nxt.g = fp_add(st_r[0].gp[0], st_r[0].gp[1]);
  end

  // Stage 3: unorm packing, second gray sum.
  always_comb begin
    s3_nxt = st_r[1];
    for (int i = 0; i < 4; i++) begin
      u[i] = fp_to_u16(st_r[1].a[i]);
    end
    if (st_r[1].fmt == FMT_RGBA8) begin
      s3_nxt.w0 = {32'd0, u[3][7:0], u[2][7:0], u[1][7:0], u[0][7:0]};
    end else if (st_r[1].fmt == FMT_RGBA16) begin
      s3_nxt.w0 = {u[3], u[2], u[1], u[0]};
    end
    s3_nxt.g = fp_add(st_r[1].g, st_r[1].gp[2]);
  end

  // Stage 4 and 5: gray to 8-bit unorm.
  always_comb begin
    s4_nxt      = st_r[2];
    s4_nxt.a[0] = fp_mul(fp_clamp01(st_r[2].g), F_255);
    s5_nxt      = st_r[3];
    s5_nxt.a[0] = fp_add(st_r[3].a[0], F_HALF);
  end

  // Final word selection into the result register.
  always_comb begin
    gu = fp_to_u16(st_r[4].a[0]);
    case (st_r[4].fmt)
      FMT_RGBA8, FMT_RGBA16, FMT_RGBA_HALF, FMT_RGBA_F32: w_nxt = st_r[4].w0;
      FMT_GRAY8:     w_nxt = {56'd0, gu[7:0]};
      FMT_GRAY_HALF: w_nxt = {48'd0, is_nan(st_r[4].g) ? H_INF : to_half(st_r[4].g)};
      FMT_GRAY_F32:  w_nxt = {32'd0, is_nan(st_r[4].g) ? F_QNAN : st_r[4].g};
      default:       w_nxt = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_v_r     <= 1'b0;
      out_phase_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[3:0], q_valid};
      end
      if (v_r[4] && en) begin
        out_v_r     <= 1'b1;
        out_phase_r <= 1'b0;
      end else if (pop && out_v_r) begin
        if (out_two_r && !out_phase_r) begin
          out_phase_r <= 1'b1;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= s1_nxt;
      st_r[1] <= s2_nxt;
      st_r[2] <= s3_nxt;
      st_r[3] <= s4_nxt;
      st_r[4] <= s5_nxt;
    end
    if (v_r[4] && en) begin
      out_w0_r  <= w_nxt;
      out_w1_r  <= st_r[4].w1;
      out_cnt_r <= fmt_bytes(st_r[4].fmt);
      out_two_r <= (st_r[4].fmt == FMT_RGBA_F32);
    end
  end

  assign empty           = !out_v_r;
  assign out_packed_word = out_phase_r ? out_w1_r : out_w0_r;
  assign out_byte_count  = out_cnt_r;
  assign out_last        = !out_two_r || out_phase_r;

endmodule

// ===== rtl/float_pixel_format_packer.sv =====
`timescale 1ns / 1ps
// An accepted item is written into the queue, then passes the five float
// pipeline stages and one result register before it shows at the result
// ports. Throughput: one item per cycle while the result port is popped
// without stall; rgba float32 items take two pops each at the result port.
// Reset (rst_n low, synchronous) empties the queue and pipeline and sets the
// format register to rgba8.
// ----------------------------------------------------------------------------
// Float pixel format packer
// Converts an RGBA single-precision pixel to the selected format and emits it
// as little-endian 64-bit words.
// ----------------------------------------------------------------------------
module float_pixel_format_packer import fpp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_out_format,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_red,
  input  logic [31:0] in_green,
  input  logic [31:0] in_blue,
  input  logic [31:0] in_alpha,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_packed_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last
);

  // The front end tags each item with the current format and queues it; the
  // back end drains the queue whenever its pipeline can move, so an input
  // stall and a result stall never block each other directly.
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  fpp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_out_format (cfg_out_format),
    .push           (push),
    .full           (full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // The back end spreads the float steps over its pipeline stages; the result register
  // sends a second word for rgba float32 before taking the next item.
  fpp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_packed_word (out_packed_word),
    .out_byte_count  (out_byte_count),
    .out_last        (out_last)
  );

`ifndef ASSERT_OFF
  // Only the two-word format produces a word without last, and it is full.
  a_first_word_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_byte_count == 4'd8))
    else $error("first of two words is not eight bytes");

  // Popping the first of two words must leave the second one waiting.
  a_second_word: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=> (!empty && out_last))
    else $error("second word missing after first pop");

  // Byte count is always one of the format sizes.
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_byte_count == 4'd1 || out_byte_count == 4'd2 ||
                out_byte_count == 4'd4 || out_byte_count == 4'd8))
    else $error("illegal byte count");
`endif

endmodule
